// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define QFN_ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion on clk_i and rst_ni.
`define QFN_ASSERT(label, prop) \
  `QFN_ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

// ===== rtl/qfn_pkg.sv =====
`timescale 1ns / 1ps
package qfn_pkg;

  localparam int MaxQuads  = 4096;
  localparam int CountW    = 13;
  localparam int SlotW     = 12;
  localparam int DropW     = 16;
  localparam int CoordW    = 24;
  localparam int EdgeW     = CoordW + 1;
  localparam int ProdW     = 2 * EdgeW;
  localparam int CrossW    = ProdW + 1;
  localparam int MagW      = ProdW;
  localparam int HalfW     = MagW / 2;
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = SqW + 2;
  localparam int RootW     = SumW / 2;
  localparam int RemW      = RootW + 1;
  localparam int DivRemW   = RootW + 1;
  localparam int QuotW     = 16;
  localparam int NormW     = 16;
  localparam int ThrW      = 32;
  localparam int StepW     = 6;
  localparam int RootSteps = RootW;
  localparam int DivSteps  = QuotW;
  localparam logic [NormW-1:0] Q14One = NormW'(16384);
  localparam logic [CountW-1:0] CapMax = CountW'(MaxQuads);

  localparam int AddrW = 4;
  localparam logic [1:0] RegCapacity  = 2'd0;
  localparam logic [1:0] RegEnable    = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;
  localparam logic [1:0] RegTwoSided  = 2'd3;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
    logic [7:0]               palette_in;
    logic [7:0]               flags_in;
  } qfn_in_t;

  typedef struct packed {
    logic                    accepted;
    logic [SlotW-1:0]        slot;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic [7:0]              palette_out;
    logic [7:0]              flags_out;
    logic [DropW-1:0]        drop_count;
  } qfn_out_t;

  typedef struct packed {
    logic [CountW-1:0] capacity;
    logic              list_enabled;
    logic [ThrW-1:0]   threshold;
    logic [2:0]        two_sided_bit;
  } qfn_cfg_t;

  typedef enum logic [3:0] {
    DpNone,
    DpEdge,
    DpProd,
    DpCross,
    DpPart,
    DpSquare,
    DpSum,
    DpRoot,
    DpDivInit,
    DpDiv
  } qfn_dp_op_e;

  typedef struct packed {
    logic       take;
    qfn_dp_op_e op;
    logic       emit;
  } qfn_cmd_t;

  typedef struct packed {
    logic is_add;
  } qfn_status_t;

endpackage

// ===== rtl/qfn_if.sv =====
`timescale 1ns / 1ps
interface qfn_in_if import qfn_pkg::*; ();
  logic    valid;
  logic    ready;
  qfn_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qfn_out_if import qfn_pkg::*; ();
  logic     valid;
  logic     ready;
  qfn_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/qfn_cfg.sv =====
`timescale 1ns / 1ps
module qfn_cfg import qfn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output qfn_cfg_t         cfg_o
);

  qfn_cfg_t cfg_q;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity      <= CapMax;
      cfg_q.list_enabled  <= 1'b1;
      cfg_q.threshold     <= ThrW'(1);
      cfg_q.two_sided_bit <= 3'd0;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegCapacity:  cfg_q.capacity      <= pwdata[CountW-1:0];
        RegEnable:    cfg_q.list_enabled  <= pwdata[0];
        RegThreshold: cfg_q.threshold     <= pwdata;
        RegTwoSided:  cfg_q.two_sided_bit <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegCapacity:  prdata = 32'(cfg_q.capacity);
      RegEnable:    prdata = 32'(cfg_q.list_enabled);
      RegThreshold: prdata = cfg_q.threshold;
      RegTwoSided:  prdata = 32'(cfg_q.two_sided_bit);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/qfn_ctrl.sv =====
`timescale 1ns / 1ps
module qfn_ctrl import qfn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  qfn_status_t status_i,
  output qfn_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StEdge, StProd, StCross, StPart, StSquare, StSum,
    StRoot, StDivInit, StDiv, StFin
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             take;
  logic             emit;

  assign in_ready_o  = (state_q == StIdle);
  assign take        = in_ready_o & in_valid_i;
  assign emit        = (state_q == StFin) & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.take = take;
    cmd_o.emit = emit;
    unique case (state_q)
      StEdge:    cmd_o.op = DpEdge;
      StProd:    cmd_o.op = DpProd;
      StCross:   cmd_o.op = DpCross;
      StPart:    cmd_o.op = DpPart;
      StSquare:  cmd_o.op = DpSquare;
      StSum:     cmd_o.op = DpSum;
      StRoot:    cmd_o.op = DpRoot;
      StDivInit: cmd_o.op = DpDivInit;
      StDiv:     cmd_o.op = DpDiv;
      default:   cmd_o.op = DpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (take) begin
            state_q <= status_i.is_add ? StEdge : StFin;
          end
        end
        StEdge:   state_q <= StProd;
        StProd:   state_q <= StCross;
        StCross:  state_q <= StPart;
        StPart:   state_q <= StSquare;
        StSquare: state_q <= StSum;
        StSum: begin
          state_q <= StRoot;
          step_q  <= StepW'(RootSteps - 1);
        end
        StRoot: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= StDivInit;
          end
        end
        StDivInit: begin
          state_q <= StDiv;
          step_q  <= StepW'(DivSteps - 1);
        end
        StDiv: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (emit) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/qfn_datapath.sv =====
`timescale 1ns / 1ps
module qfn_datapath import qfn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qfn_cmd_t    cmd_i,
  input  qfn_in_t     item_i,
  input  qfn_cfg_t    cfg_i,
  output qfn_status_t status_o,
  output qfn_out_t    out_o
);

  logic [CountW-1:0] count_q;
  logic [DropW-1:0]  drop_q;
  logic [CountW-1:0] cap;
  logic              full;

  qfn_in_t           item_q;
  logic              res_add_q;
  logic [SlotW-1:0]  res_slot_q;
  logic [DropW-1:0]  res_drop_q;

  logic signed [EdgeW-1:0]  e1_q [3];
  logic signed [EdgeW-1:0]  e2_q [3];
  logic signed [ProdW-1:0]  p_q  [6];
  logic signed [CrossW-1:0] n    [3];
  logic [MagW-1:0]          mag_q [3];
  logic                     neg_q [3];
  logic [MagW-1:0]          hh_q [3];
  logic [MagW-1:0]          hl_q [3];
  logic [MagW-1:0]          ll_q [3];
  logic [SqW-1:0]           sq_q [3];
  logic [SumW-1:0]          s_q;
  logic [RootW-1:0]         root_q;
  logic [RemW-1:0]          rem_q;
  logic [RemW+1:0]          rem_sh;
  logic [RemW+1:0]          trial;
  logic [DivRemW-1:0]       drem_q [3];
  logic [QuotW-1:0]         quo_q  [3];
  logic [DivRemW-1:0]       dlen;
  logic [NormW-1:0]         nmag   [3];
  logic signed [NormW-1:0]  nval   [3];
  logic                     degen;
  logic [7:0]               flags_deg;
  qfn_out_t                 out_q;

  assign cap             = (cfg_i.capacity > CapMax) ? CapMax : cfg_i.capacity;
  assign full            = (count_q >= cap);
  assign status_o.is_add = (item_i.op == OpAdd) & cfg_i.list_enabled & ~full;
  assign out_o           = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= '0;
    end else if (cmd_i.take) begin
      if (item_i.op == OpClear) begin
        count_q <= '0;
        drop_q  <= '0;
      end else if (cfg_i.list_enabled && full) begin
        if (drop_q != '1) begin
          drop_q <= drop_q + 1'b1;
        end
      end else if (cfg_i.list_enabled) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q     <= item_i;
      res_add_q  <= status_o.is_add;
      res_slot_q <= count_q[SlotW-1:0];
      if (item_i.op == OpClear) begin
        res_drop_q <= '0;
      end else if (cfg_i.list_enabled && full && drop_q != '1) begin
        res_drop_q <= drop_q + 1'b1;
      end else begin
        res_drop_q <= drop_q;
      end
    end
  end

  always_comb begin
    n[0] = CrossW'(p_q[0]) - CrossW'(p_q[1]);
    n[1] = CrossW'(p_q[2]) - CrossW'(p_q[3]);
    n[2] = CrossW'(p_q[4]) - CrossW'(p_q[5]);
  end

  assign rem_sh = {rem_q, s_q[SumW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign dlen   = DivRemW'(root_q);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DpEdge: begin
        e1_q[0] <= EdgeW'(item_q.v1_x) - EdgeW'(item_q.v0_x);
        e1_q[1] <= EdgeW'(item_q.v1_y) - EdgeW'(item_q.v0_y);
        e1_q[2] <= EdgeW'(item_q.v1_z) - EdgeW'(item_q.v0_z);
        e2_q[0] <= EdgeW'(item_q.v2_x) - EdgeW'(item_q.v0_x);
        e2_q[1] <= EdgeW'(item_q.v2_y) - EdgeW'(item_q.v0_y);
        e2_q[2] <= EdgeW'(item_q.v2_z) - EdgeW'(item_q.v0_z);
      end
      DpProd: begin
        p_q[0] <= e1_q[1] * e2_q[2];
        p_q[1] <= e1_q[2] * e2_q[1];
        p_q[2] <= e1_q[2] * e2_q[0];
        p_q[3] <= e1_q[0] * e2_q[2];
        p_q[4] <= e1_q[0] * e2_q[1];
        p_q[5] <= e1_q[1] * e2_q[0];
      end
      DpCross: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= n[i][CrossW-1];
          mag_q[i] <= n[i][CrossW-1] ? MagW'(-n[i]) : MagW'(n[i]);
        end
      end
      DpPart: begin
        for (int i = 0; i < 3; i++) begin
          hh_q[i] <= mag_q[i][MagW-1:HalfW] * mag_q[i][MagW-1:HalfW];
          hl_q[i] <= mag_q[i][MagW-1:HalfW] * mag_q[i][HalfW-1:0];
          ll_q[i] <= mag_q[i][HalfW-1:0] * mag_q[i][HalfW-1:0];
        end
      end
      DpSquare: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= {hh_q[i], {MagW{1'b0}}} + (SqW'(hl_q[i]) << (HalfW + 1))
                     + SqW'(ll_q[i]);
        end
      end
      DpSum: begin
        s_q    <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
        root_q <= '0;
        rem_q  <= '0;
      end
      DpRoot: begin
        s_q <= s_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= RemW'(rem_sh - trial);
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= RemW'(rem_sh);
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      DpDivInit: begin
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= DivRemW'(mag_q[i]);
          quo_q[i]  <= '0;
        end
      end
      DpDiv: begin
        for (int i = 0; i < 3; i++) begin
          if (drem_q[i] >= dlen) begin
            drem_q[i] <= {drem_q[i][DivRemW-2:0] - dlen[DivRemW-2:0], 1'b0};
            quo_q[i]  <= {quo_q[i][QuotW-2:0], 1'b1};
          end else begin
            drem_q[i] <= {drem_q[i][DivRemW-2:0], 1'b0};
            quo_q[i]  <= {quo_q[i][QuotW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign degen = (root_q <= RootW'(cfg_i.threshold)) || (root_q == '0);
  assign flags_deg = item_q.flags_in | (8'd1 << cfg_i.two_sided_bit);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = NormW'((17'(quo_q[i]) + 17'd1) >> 1);
      if (nmag[i] > Q14One) begin
        nmag[i] = Q14One;
      end
      nval[i] = neg_q[i] ? -$signed(nmag[i]) : $signed(nmag[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.drop_count <= res_drop_q;
      if (res_add_q) begin
        out_q.accepted    <= 1'b1;
        out_q.slot        <= res_slot_q;
        out_q.palette_out <= item_q.palette_in;
        if (degen) begin
          out_q.normal_x  <= '0;
          out_q.normal_y  <= Q14One;
          out_q.normal_z  <= '0;
          out_q.flags_out <= flags_deg;
        end else begin
          out_q.normal_x  <= nval[0];
          out_q.normal_y  <= nval[1];
          out_q.normal_z  <= nval[2];
          out_q.flags_out <= item_q.flags_in;
        end
      end else begin
        out_q.accepted    <= 1'b0;
        out_q.slot        <= '0;
        out_q.palette_out <= '0;
        out_q.normal_x    <= '0;
        out_q.normal_y    <= '0;
        out_q.normal_z    <= '0;
        out_q.flags_out   <= '0;
      end
    end
  end

endmodule

// ===== rtl/quad_face_normal_append_core.sv =====
`timescale 1ns / 1ps
// Face normal of a quad, appended to a bounded list.
// in_i carries one item per transfer: an add (three vertices, palette, flags)
// or a clear. out_o returns exactly one result per item, in order.
// Registers on the APB port: capacity (0x0), list enable (0x4), degenerate
// threshold (0x8), two-sided flag bit (0xC); write them only while idle.
// One item is worked at a time; in_i is ready only while the core is idle.
// An add that is appended runs from transfer to result through six setup
// steps (edges, products, cross product, partial products, squares, sum),
// 51 steps of the bit-serial square root and 16 steps of the three
// parallel dividers. A clear, a rejected add or a dropped add skips them.
// The result sits in an output register; the core takes the next item while
// it waits, and holds a finished result of that item until out_o is taken.
// Reset empties the list, zeroes the drop counter, restores the register
// defaults and leaves no result pending.
module quad_face_normal_append_core import qfn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  qfn_in_if.sink           in_i,
  qfn_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  qfn_cfg_t    cfg;
  qfn_cmd_t    cmd;
  qfn_status_t status;

  qfn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qfn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  qfn_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_i.data),
    .cfg_i    (cfg),
    .status_o (status),
    .out_o    (out_o.data)
  );

endmodule

// ===== rtl/qfn_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qfn_checker import qfn_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input qfn_out_t out_data_i
);

  logic reject_clean;
  logic normal_y_in_range;

  assign reject_clean = (out_data_i.slot == '0) && (out_data_i.normal_x == '0) &&
                        (out_data_i.flags_out == '0);
  assign normal_y_in_range = ($signed(out_data_i.normal_y) <= $signed(Q14One)) &&
                             ($signed(out_data_i.normal_y) >= -$signed(Q14One));

  `QFN_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `QFN_ASSERT(a_one_at_a_time, in_valid_i && in_ready_i |=> !in_ready_i)
  `QFN_ASSERT(a_reject_clean, out_valid_i && !out_data_i.accepted |-> reject_clean)
  `QFN_ASSERT(a_normal_range, out_valid_i && out_data_i.accepted |-> normal_y_in_range)

endmodule

bind quad_face_normal_append_core qfn_checker u_qfn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
